// ----- src/sdv_pkg.sv -----
// shared types and constants of the score delta varint bit packer
package sdv_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_FIELD = 2'd1,
        ACT_SCORE = 2'd2,
        ACT_FLUSH = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_FINISH
    } t_state;

    localparam logic [15:0] SIGN_FOLD_MASK = 16'h7FFF;
    localparam logic [2:0]  BLOCK_BITS_RESET = 3'd4;
    localparam logic [3:0]  BYTE_BITS = 4'd8;

    // request to the bit merge unit
    typedef struct packed {
        logic [7:0] partial;
        logic [3:0] free;
        logic [7:0] chunk;
        logic [3:0] len;
    } t_ins_req;

    // answer of the bit merge unit
    typedef struct packed {
        logic       byte_done;
        logic [7:0] done_byte;
        logic [7:0] partial;
        logic [3:0] free;
    } t_ins_res;

endpackage

// ----- src/sdv_in_if.sv -----
// input channel: one action beat
interface sdv_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [7:0]         field_value;
    logic [3:0]         field_bits;
    logic signed [15:0] score;

    modport source (output valid, action, field_value, field_bits, score, input ready);
    modport sink   (input valid, action, field_value, field_bits, score, output ready);
endinterface

// ----- src/sdv_out_if.sv -----
// output channel: one packed byte beat
interface sdv_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [15:0] ply_count;
    logic        last;

    modport source (output valid, out_byte, ply_count, last, input ready);
    modport sink   (input valid, out_byte, ply_count, last, output ready);
endinterface

// ----- src/sdv_bit_merge.sv -----
// shared shift and merge unit: appends up to eight bits to the open byte
module sdv_bit_merge (
    input  sdv_pkg::t_ins_req i_req,
    output sdv_pkg::t_ins_res o_res
);

    logic [3:0]  free_eff;
    logic [3:0]  shamt;
    logic [15:0] window;

    always_comb begin
        // no open byte means a fresh empty byte
        free_eff = (i_req.free == 4'd0) ? sdv_pkg::BYTE_BITS : i_req.free;
        shamt    = 4'(sdv_pkg::BYTE_BITS + free_eff - i_req.len);
        window   = {i_req.partial, 8'h00} | ({8'h00, i_req.chunk} << shamt);

        if (i_req.len >= free_eff) begin
            o_res.byte_done = 1'b1;
            o_res.done_byte = window[15:8];
            o_res.partial   = window[7:0];
            o_res.free      = (i_req.len == free_eff) ? 4'd0 : shamt;
        end else begin
            o_res.byte_done = 1'b0;
            o_res.done_byte = window[15:8];
            o_res.partial   = window[15:8];
            o_res.free      = free_eff - i_req.len;
        end
    end

endmodule

// ----- src/score_delta_varint_bit_packer.sv -----
// top level of the score delta varint bit packer
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    action, field_value, field_bits, score
//  o_out     out  valid/ready    out_byte, ply_count, last
//  i_cfg_*   in   write enable   vle_block_bits (3 bits)
//
//  sequencing: a clear, a flush without an open byte and a field of zero bits
//  are done in idle; a flush with an open byte goes through finish; a field or
//  a score goes through chunk and then finish, in the single shift and merge unit
//  that handles one block (or one field) per cycle unless a held byte stalls it
//  reset: synchronous active-low i_rst_n clears the sequencer, stored score,
//  ply counter, open byte and block size (back to 4)
//  stalls: a held output beat only blocks the sequencer when a second byte is
//  ready to leave; input beats are taken only while the sequencer is idle
module score_delta_varint_bit_packer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_data,
    sdv_in_if.sink           i_in,
    sdv_out_if.source        o_out
);

    // sequencer state
    sdv_pkg::t_state r_state, n_state;

    // configuration
    logic [2:0]  r_block_bits;

    // packer state
    logic [7:0]  r_partial, n_partial;
    logic [3:0]  r_free, n_free;
    logic [15:0] r_prev_score, n_prev_score;
    logic [15:0] r_plies, n_plies;

    // per item work registers
    logic        r_is_score, n_is_score;
    logic [15:0] r_v, n_v;
    logic [7:0]  r_chunk, n_chunk;
    logic [3:0]  r_chunk_len, n_chunk_len;

    // completed byte held back until we know whether it is the last one
    logic [7:0]  r_hold, n_hold;
    logic        r_hold_valid, n_hold_valid;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic [15:0] r_out_ply, n_out_ply;
    logic        r_out_last, n_out_last;

    // datapath helpers
    logic [2:0]  bs;
    logic [7:0]  mask8;
    logic [15:0] v_shift;
    logic        cont;
    logic [15:0] diff;
    logic [15:0] folded;
    logic [3:0]  fbits_sat;
    logic [8:0]  fmask;
    logic        accept;
    logic        out_free;
    logic        chunk_stall;
    logic        chunk_last;

    sdv_pkg::t_ins_req ins_req;
    sdv_pkg::t_ins_res ins_res;

    sdv_bit_merge u_merge (
        .i_req (ins_req),
        .o_res (ins_res)
    );

    assign i_in.ready     = (r_state == sdv_pkg::ST_IDLE);
    assign accept         = i_in.valid && i_in.ready;
    assign out_free       = !r_out_valid || o_out.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.ply_count = r_out_ply;
    assign o_out.last      = r_out_last;

    always_comb begin
        // block size zero is taken as one
        bs      = (r_block_bits == 3'd0) ? 3'd1 : r_block_bits;
        mask8   = 8'((8'd1 << bs) - 8'd1);
        v_shift = r_v >> bs;
        cont    = (v_shift != 16'd0);

        // wrapped delta, sign fold, rotate left one
        diff   = 16'(i_in.score) - r_prev_score;
        folded = diff[15] ? (diff ^ sdv_pkg::SIGN_FOLD_MASK) : diff;
        folded = {folded[14:0], folded[15]};

        // raw field count saturates at eight
        fbits_sat = (i_in.field_bits > sdv_pkg::BYTE_BITS) ? sdv_pkg::BYTE_BITS
                                                           : i_in.field_bits;
        fmask     = (9'd1 << fbits_sat) - 9'd1;

        // continue bit goes out first, above the data bits
        ins_req.partial = r_partial;
        ins_req.free    = r_free;
        if (r_is_score) begin
            ins_req.chunk = (r_v[7:0] & mask8) | (8'(cont) << bs);
            ins_req.len   = {1'b0, bs} + 4'd1;
        end else begin
            ins_req.chunk = r_chunk;
            ins_req.len   = r_chunk_len;
        end

        // an older held byte must leave before a new one can be held
        chunk_stall = ins_res.byte_done && r_hold_valid && !out_free;
        chunk_last  = !r_is_score || !cont;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sdv_pkg::ST_IDLE: begin
                if (accept) begin
                    case (sdv_pkg::t_action'(i_in.action))
                        sdv_pkg::ACT_FIELD: begin
                            if (fbits_sat != 4'd0) n_state = sdv_pkg::ST_CHUNK;
                        end
                        sdv_pkg::ACT_SCORE: n_state = sdv_pkg::ST_CHUNK;
                        sdv_pkg::ACT_FLUSH: begin
                            if (r_free != 4'd0) n_state = sdv_pkg::ST_FINISH;
                        end
                        default: n_state = sdv_pkg::ST_IDLE;
                    endcase
                end
            end
            sdv_pkg::ST_CHUNK: begin
                if (!chunk_stall && chunk_last) n_state = sdv_pkg::ST_FINISH;
            end
            sdv_pkg::ST_FINISH: begin
                if (!r_hold_valid || out_free) n_state = sdv_pkg::ST_IDLE;
            end
            default: n_state = sdv_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_partial    = r_partial;
        n_free       = r_free;
        n_prev_score = r_prev_score;
        n_plies      = r_plies;
        n_is_score   = r_is_score;
        n_v          = r_v;
        n_chunk      = r_chunk;
        n_chunk_len  = r_chunk_len;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_ply    = r_out_ply;
        n_out_last   = r_out_last;

        case (r_state)
            sdv_pkg::ST_IDLE: begin
                if (accept) begin
                    case (sdv_pkg::t_action'(i_in.action))
                        sdv_pkg::ACT_CLEAR: begin
                            n_partial    = 8'h00;
                            n_free       = 4'd0;
                            n_plies      = 16'd0;
                            n_prev_score = 16'd0 - 16'(i_in.score);
                        end
                        sdv_pkg::ACT_FIELD: begin
                            n_is_score  = 1'b0;
                            n_chunk     = i_in.field_value & fmask[7:0];
                            n_chunk_len = fbits_sat;
                        end
                        sdv_pkg::ACT_SCORE: begin
                            n_is_score   = 1'b1;
                            n_v          = folded;
                            n_prev_score = 16'd0 - 16'(i_in.score);
                            n_plies      = r_plies + 16'd1;
                        end
                        sdv_pkg::ACT_FLUSH: begin
                            // open partial byte goes out as the only beat
                            if (r_free != 4'd0) begin
                                n_hold       = r_partial;
                                n_hold_valid = 1'b1;
                            end
                            n_partial = 8'h00;
                            n_free    = 4'd0;
                        end
                        default: n_partial = r_partial;
                    endcase
                end
            end
            sdv_pkg::ST_CHUNK: begin
                if (!chunk_stall) begin
                    n_partial = ins_res.partial;
                    n_free    = ins_res.free;
                    n_v       = v_shift;
                    if (ins_res.byte_done) begin
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = r_hold;
                            n_out_ply   = r_plies;
                            n_out_last  = 1'b0;
                        end
                        n_hold       = ins_res.done_byte;
                        n_hold_valid = 1'b1;
                    end
                end
            end
            sdv_pkg::ST_FINISH: begin
                // final beat of the item carries last
                if (r_hold_valid && out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_hold;
                    n_out_ply    = r_plies;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                end
            end
            default: n_hold_valid = r_hold_valid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sdv_pkg::ST_IDLE;
            r_block_bits <= sdv_pkg::BLOCK_BITS_RESET;
            r_partial    <= 8'h00;
            r_free       <= 4'd0;
            r_prev_score <= 16'd0;
            r_plies      <= 16'd0;
            r_is_score   <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) r_block_bits <= i_cfg_data;
            r_partial    <= n_partial;
            r_free       <= n_free;
            r_prev_score <= n_prev_score;
            r_plies      <= n_plies;
            r_is_score   <= n_is_score;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_chunk     <= n_chunk;
        r_chunk_len <= n_chunk_len;
        r_hold      <= n_hold;
        r_out_byte  <= n_out_byte;
        r_out_ply   <= n_out_ply;
        r_out_last  <= n_out_last;
    end

    // the held byte is always drained before new work is taken
    a_idle_no_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdv_pkg::ST_IDLE) |-> !r_hold_valid)
        else $error("held byte left over in idle");

    // an open byte never has all eight bits free
    a_free_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free < sdv_pkg::BYTE_BITS)
        else $error("free bit count out of range");

    // a clear drops the open byte and restarts the ply count
    a_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.action == sdv_pkg::ACT_CLEAR))
            |=> (r_free == 4'd0) && (r_plies == 16'd0))
        else $error("clear did not reset packer state");

endmodule

// ----- tb/tb_score_delta_varint_bit_packer.sv -----
// testbench of the score delta varint bit packer: scoreboard, drivers and stimulus
module tb_score_delta_varint_bit_packer;
    timeunit 1ns;
    timeprecision 1ps;

    // one input beat as the stimulus sees it
    typedef struct {
        sdv_pkg::t_action act;
        logic [7:0]       fv;
        logic [3:0]       fb;
        logic [15:0]      sc;
    } t_move_item;

    // one packed byte beat as the block should deliver it
    typedef struct {
        logic [7:0]  data;
        logic [15:0] ply;
        logic        last_flag;
    } t_byte_beat;

    // keeps its own copy of the packer state and the expected byte beats
    class packed_byte_scoreboard;
        logic [2:0]  block_bits;
        logic [7:0]  open_byte;
        logic [3:0]  open_free;
        logic [15:0] stored_score;
        logic [15:0] plies;
        t_byte_beat  pending[$];
        t_byte_beat  fresh[$];
        int          errors;

        function new();
            block_bits   = sdv_pkg::BLOCK_BITS_RESET;
            open_byte    = '0;
            open_free    = '0;
            stored_score = '0;
            plies        = '0;
            errors       = 0;
        endfunction

        function void set_block_bits(logic [2:0] v);
            block_bits = v;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // msb-first bit append, a byte leaves as soon as it fills
        function void append_bit(logic b);
            t_byte_beat done;
            if (open_free == 0 || open_free > sdv_pkg::BYTE_BITS) begin
                open_byte = '0;
                open_free = sdv_pkg::BYTE_BITS;
            end
            if (b)
                open_byte[open_free - 1] = 1'b1;
            open_free = open_free - 4'd1;
            if (open_free == 0) begin
                done.data      = open_byte;
                done.ply       = '0;
                done.last_flag = 1'b0;
                fresh.push_back(done);
                open_byte = '0;
            end
        endfunction

        function void append_bits(logic [15:0] val, int n);
            for (int i = n; i > 0; i--)
                append_bit(val[i - 1]);
        endfunction

        // negative deltas get their magnitude bits inverted, then the sign rotates to bit 0
        function logic [15:0] fold_delta(logic [15:0] d);
            if (d[15])
                d = d ^ sdv_pkg::SIGN_FOLD_MASK;
            return {d[14:0], d[15]};
        endfunction

        function void note_input(t_move_item it);
            int          n;
            int          bs;
            logic [15:0] mask;
            logic [15:0] v;
            logic [15:0] blk;
            fresh.delete();
            case (it.act)
                sdv_pkg::ACT_CLEAR: begin
                    open_byte    = '0;
                    open_free    = '0;
                    plies        = '0;
                    stored_score = 16'd0 - it.sc;
                end
                sdv_pkg::ACT_FIELD: begin
                    n = (it.fb > 8) ? 8 : int'(it.fb);
                    for (int i = n; i > 0; i--)
                        append_bit(it.fv[i - 1]);
                end
                sdv_pkg::ACT_SCORE: begin
                    bs   = (block_bits == 0) ? 1 : int'(block_bits);
                    mask = (16'd1 << bs) - 16'd1;
                    v    = fold_delta(it.sc - stored_score);
                    do begin
                        blk = (v & mask) | (16'(v > mask) << bs);
                        append_bits(blk, bs + 1);
                        v = v >> bs;
                    end while (v != 0);
                    stored_score = 16'd0 - it.sc;
                    plies        = plies + 16'd1;
                end
                default: begin
                    if (open_free >= 1 && open_free <= 7)
                        fresh.push_back('{data: open_byte, ply: 16'd0, last_flag: 1'b0});
                    open_byte = '0;
                    open_free = '0;
                end
            endcase
            foreach (fresh[k]) begin
                fresh[k].ply       = plies;
                fresh[k].last_flag = (k == fresh.size() - 1);
                pending.push_back(fresh[k]);
            end
        endfunction

        function void check_result(logic [7:0] b, logic [15:0] ply, logic l);
            t_byte_beat want;
            if (pending.size() == 0) begin
                errors++;
                $error("out_byte: no beat expected, actual %02h", b);
                return;
            end
            want = pending.pop_front();
            if (b !== want.data) begin
                errors++;
                $error("out_byte: expected %02h, actual %02h", want.data, b);
            end
            if (ply !== want.ply) begin
                errors++;
                $error("ply_count: expected %0d, actual %0d", want.ply, ply);
            end
            if (l !== want.last_flag) begin
                errors++;
                $error("last: expected %0b, actual %0b", want.last_flag, l);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_data;

    sdv_in_if  in_bus ();
    sdv_out_if out_bus ();

    score_delta_varint_bit_packer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    packed_byte_scoreboard sb;

    // score of the last clear or score beat sent, used to aim deltas small
    logic [15:0] last_score = '0;
    int          items_sent = 0;
    // remaining beats in a stretch with no idling, one per side
    int          in_calm    = 0;
    int          out_calm   = 0;

    always #6 i_clk = ~i_clk;

    // random idling, mostly short, with stretches of none at all
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 40);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // mostly small deltas around the stored score, plus extremes and noise
    function automatic logic [15:0] pick_score();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2:    return 16'($urandom_range(0, 65535));
            default: return 16'd0 - last_score + 16'($urandom_range(0, 600)) - 16'd300;
        endcase
    endfunction

    // one input beat: optional idle, then hold valid until the block takes it
    task automatic send_item(input sdv_pkg::t_action act, input logic [7:0] fv,
                             input logic [3:0] fb, input logic [15:0] sc);
        t_move_item it;
        int         gap;
        it  = '{act: act, fv: fv, fb: fb, sc: sc};
        gap = draw_wait(in_calm);
        if (gap > 0) begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid       = 1'b1;
        in_bus.action      = act;
        in_bus.field_value = fv;
        in_bus.field_bits  = fb;
        in_bus.score       = sc;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        sb.note_input(it);
        if (act == sdv_pkg::ACT_CLEAR || act == sdv_pkg::ACT_SCORE)
            last_score = sc;
        items_sent++;
        @(negedge i_clk);
    endtask

    // drained: nothing expected, then enough cycles for a long score beat to finish
    task automatic wait_idle();
        in_bus.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_block_bits(input logic [2:0] v);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_block_bits(v);
    endtask

    // mostly whole games (clear, move fields with scores, usually a flush), some raw noise
    task automatic run_random(input int count);
        int          stop_at;
        int          plies_n;
        logic [3:0]  fb;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 80) begin
                send_item(sdv_pkg::ACT_CLEAR, 8'($urandom), 4'($urandom), pick_score());
                plies_n = $urandom_range(1, 12);
                for (int p = 0; p < plies_n; p++) begin
                    case ($urandom_range(0, 19))
                        0:       fb = 4'd0;
                        1:       fb = 4'($urandom_range(9, 15));
                        default: fb = 4'($urandom_range(1, 8));
                    endcase
                    send_item(sdv_pkg::ACT_FIELD, 8'($urandom), fb, 16'($urandom));
                    send_item(sdv_pkg::ACT_SCORE, 8'($urandom), 4'($urandom),
                              pick_score());
                end
                if ($urandom_range(0, 3) != 0)
                    send_item(sdv_pkg::ACT_FLUSH, 8'($urandom), 4'($urandom),
                              16'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(sdv_pkg::t_action'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)),
                              4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // output side: random back-pressure per beat
    initial begin
        int stall;
        out_bus.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = draw_wait(out_calm);
            if (stall > 0) begin
                out_bus.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_bus.ready = 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // every accepted byte beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
            sb.check_result(out_bus.out_byte, out_bus.ply_count, out_bus.last);
    end

    initial begin
        sb                 = new();
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = '0;
        in_bus.valid       = 1'b0;
        in_bus.action      = sdv_pkg::ACT_CLEAR;
        in_bus.field_value = '0;
        in_bus.field_bits  = '0;
        in_bus.score       = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part at the reset block size of four
        send_item(sdv_pkg::ACT_FLUSH, 8'h00, 4'd0, 16'h0000);  // nothing open, no beat
        send_item(sdv_pkg::ACT_CLEAR, 8'h00, 4'd0, 16'h8000);  // most negative base
        send_item(sdv_pkg::ACT_SCORE, 8'h00, 4'd0, 16'h7FFF);  // difference wraps around
        send_item(sdv_pkg::ACT_FIELD, 8'hFF, 4'd8, 16'h0000);  // full byte of ones
        send_item(sdv_pkg::ACT_FIELD, 8'h5A, 4'd0, 16'h0000);  // zero width appends nothing
        send_item(sdv_pkg::ACT_FIELD, 8'hA5, 4'd15, 16'h0000); // width above eight saturates
        send_item(sdv_pkg::ACT_FIELD, 8'hF8, 4'd3, 16'h0000);  // only the low bits count
        send_item(sdv_pkg::ACT_FLUSH, 8'h00, 4'd0, 16'h0000);  // bytes filled exactly, no beat
        send_item(sdv_pkg::ACT_FLUSH, 8'h00, 4'd0, 16'h0000);  // already closed
        send_item(sdv_pkg::ACT_SCORE, 8'h00, 4'd0, 16'h8000);
        send_item(sdv_pkg::ACT_SCORE, 8'h00, 4'd0, 16'h0000);
        send_item(sdv_pkg::ACT_SCORE, 8'h00, 4'd0, 16'h7FFF);
        send_item(sdv_pkg::ACT_FIELD, 8'h01, 4'd1, 16'h0000);
        send_item(sdv_pkg::ACT_CLEAR, 8'hFF, 4'd15, 16'h7FFF); // open byte is dropped
        send_item(sdv_pkg::ACT_SCORE, 8'h00, 4'd0, 16'h8001);
        send_item(sdv_pkg::ACT_FIELD, 8'h00, 4'd9, 16'h0000);
        send_item(sdv_pkg::ACT_SCORE, 8'h00, 4'd0, 16'hFFFF);
        send_item(sdv_pkg::ACT_FIELD, 8'h80, 4'd8, 16'h0000);
        send_item(sdv_pkg::ACT_FLUSH, 8'h00, 4'd0, 16'h0000);

        // random phases: narrowest, widest, zero (taken as one), then random sizes
        wait_idle();
        write_block_bits(3'd1);
        run_random(75);
        wait_idle();
        write_block_bits(3'd7);
        run_random(75);
        wait_idle();
        write_block_bits(3'd0);
        run_random(75);
        repeat (2) begin
            wait_idle();
            write_block_bits(3'($urandom_range(0, 7)));
            run_random(75);
        end

        wait_idle();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard
    initial begin
        #8ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/sdv_pkg.sv
src/sdv_in_if.sv
src/sdv_out_if.sv
src/sdv_bit_merge.sv
src/score_delta_varint_bit_packer.sv
tb/tb_score_delta_varint_bit_packer.sv
